FILE: rtl/sct_pkg.sv
package sct_pkg;

  // Token kinds as delivered on the result channel.
  localparam logic [4:0] KIND_INT     = 5'd0;
  localparam logic [4:0] KIND_FLOAT   = 5'd1;
  localparam logic [4:0] KIND_IDENT   = 5'd2;
  localparam logic [4:0] KIND_LET     = 5'd3;
  localparam logic [4:0] KIND_FUNC    = 5'd4;
  localparam logic [4:0] KIND_STRING  = 5'd5;
  localparam logic [4:0] KIND_LPAREN  = 5'd6;
  localparam logic [4:0] KIND_RPAREN  = 5'd7;
  localparam logic [4:0] KIND_ASSIGN  = 5'd8;
  localparam logic [4:0] KIND_PLUS    = 5'd9;
  localparam logic [4:0] KIND_MINUS   = 5'd10;
  localparam logic [4:0] KIND_SLASH   = 5'd11;
  localparam logic [4:0] KIND_STAR    = 5'd12;
  localparam logic [4:0] KIND_PERCENT = 5'd13;
  localparam logic [4:0] KIND_SEMI    = 5'd14;
  localparam logic [4:0] KIND_COMMA   = 5'd15;
  localparam logic [4:0] KIND_DOT     = 5'd16;
  localparam logic [4:0] KIND_LBRACE  = 5'd17;
  localparam logic [4:0] KIND_RBRACE  = 5'd18;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NUMBER  = 2'd1;
  localparam logic [1:0] ERR_STRING  = 2'd2;
  localparam logic [1:0] ERR_ILLEGAL = 2'd3;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Character queue between the front and the back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // Classified character as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] code;
    logic       is_zero;
    logic       is_nl;
    logic       is_ws;
    logic       is_digit;
    logic       is_alpha;
    logic       is_minus;
    logic       is_dot;
    logic       is_quote;
    logic       is_under;
    logic       is_op;
    logic [4:0] op_kind;
  } cls_t;

  // One result transaction.
  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  err;
    logic [15:0] line;
    logic [15:0] offset;
    logic [15:0] length;
    logic        done;
  } tok_t;

endpackage

FILE: rtl/script_char_tokenizer.sv
// Streaming tokenizer for a small scripting language.
// Input channel (in_valid/in_ready/in_char_code): one source byte per
// transaction; byte 0 ends the run. Result channel (out_valid/out_ready and
// the out_ fields): one transaction per token, plus a final transaction with
// out_stream_done set when byte 0 has been seen.
// A character is classified in the cycle it is accepted and written to a
// four-entry queue. The lexer state machine takes it from that registered
// queue and writes its results to a four-entry result queue, from which a
// byte's results are offered in order. One byte is taken per cycle as long
// as results are drained; a byte that yields two results needs two result
// transactions, and the lexer waits when its result queue has fewer than
// two free entries.
// Numbers, identifiers and a held minus end one byte late (the byte after
// the token decides it), so their result follows the transaction of the
// next byte; strings end on their closing quote and operators at once.
// After an error the block drops bytes until byte 0, which closes the run
// with the error code. Reset empties both queues and starts a new run at
// line 1, offset 0. When the receiver stalls, results wait in the result
// queue and then the character queue fills and in_ready falls.
module script_char_tokenizer
  import sct_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_text_length,
  output logic        out_stream_done
);

  logic push_valid;
  logic push_ready;
  cls_t push_cls;
  logic pop_valid;
  logic pop_ready;
  cls_t pop_cls;

  // Classifier.
  sct_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cls     (push_cls)
  );

  // Character queue.
  sct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cls   (push_cls),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cls    (pop_cls)
  );

  // Lexer state machine and result queue.
  sct_back #(
    .CW (COUNTER_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (pop_valid),
    .q_ready          (pop_ready),
    .q_cls            (pop_cls),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_error_code   (out_error_code),
    .out_start_line   (out_start_line),
    .out_start_offset (out_start_offset),
    .out_text_length  (out_text_length),
    .out_stream_done  (out_stream_done)
  );

  // The closing transaction of a run carries no token.
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_text_length == 16'd0 &&
                                     out_token_kind == KIND_INT)
    else $error("end-of-run result carries a token");

  // Error results report kind zero.
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_token_kind == KIND_INT)
    else $error("error result with a nonzero token kind");

  // Operators are single characters and never errors.
  a_op_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind >= KIND_LPAREN |->
      out_text_length == 16'd1 && out_error_code == ERR_NONE && !out_stream_done)
    else $error("operator token with a wrong length");

  // Lines count from one.
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_start_line != 16'd0)
    else $error("result with line number zero");

endmodule

FILE: rtl/sct_front.sv
module sct_front
  import sct_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  output logic       push_valid,
  input  logic       push_ready,
  output cls_t       push_cls
);

  logic       op_hit;
  logic [4:0] op_kind;

  // Accept whenever the queue has a free slot.
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  // Single-character operators.
  always_comb begin
    op_hit  = 1'b1;
    op_kind = KIND_INT;
    unique case (in_char_code)
      8'h28:   op_kind = KIND_LPAREN;
      8'h29:   op_kind = KIND_RPAREN;
      8'h3D:   op_kind = KIND_ASSIGN;
      8'h2B:   op_kind = KIND_PLUS;
      CH_MINUS: op_kind = KIND_MINUS;
      8'h2F:   op_kind = KIND_SLASH;
      8'h2A:   op_kind = KIND_STAR;
      8'h25:   op_kind = KIND_PERCENT;
      8'h3B:   op_kind = KIND_SEMI;
      8'h2C:   op_kind = KIND_COMMA;
      CH_DOT:  op_kind = KIND_DOT;
      8'h7B:   op_kind = KIND_LBRACE;
      8'h7D:   op_kind = KIND_RBRACE;
      default: op_hit  = 1'b0;
    endcase
  end

  // Character classes used by the lexer state machine.
  always_comb begin
    push_cls.code     = in_char_code;
    push_cls.is_zero  = (in_char_code == CH_NUL);
    push_cls.is_nl    = (in_char_code == CH_NL);
    push_cls.is_ws    = (in_char_code == CH_SPACE) || (in_char_code == CH_TAB);
    push_cls.is_digit = (in_char_code >= 8'h30) && (in_char_code <= 8'h39);
    push_cls.is_alpha = ((in_char_code >= 8'h61) && (in_char_code <= 8'h7A)) ||
                        ((in_char_code >= 8'h41) && (in_char_code <= 8'h5A));
    push_cls.is_minus = (in_char_code == CH_MINUS);
    push_cls.is_dot   = (in_char_code == CH_DOT);
    push_cls.is_quote = (in_char_code == CH_QUOTE);
    push_cls.is_under = (in_char_code == CH_UNDER);
    push_cls.is_op    = op_hit;
    push_cls.op_kind  = op_kind;
  end

endmodule

FILE: rtl/sct_queue.sv
module sct_queue
  import sct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cls_t push_cls,
  output logic pop_valid,
  input  logic pop_ready,
  output cls_t pop_cls
);

  cls_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r;
  logic [Q_PTR_W-1:0] rd_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push;
  logic               pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cls    = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cls;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

endmodule

FILE: rtl/sct_back.sv
module sct_back
  import sct_pkg::*;
#(
  parameter int unsigned CW = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cls_t        q_cls,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_text_length,
  output logic        out_stream_done
);

  typedef enum logic [2:0] {
    M_IDLE, M_MINUS, M_NUMBER, M_IDENT, M_STRING, M_HALT1, M_HALT2, M_HALT3
  } mode_t;

  localparam logic [7:0] CH_LO_L = 8'h6C;
  localparam logic [7:0] CH_LO_E = 8'h65;
  localparam logic [7:0] CH_LO_T = 8'h74;
  localparam logic [7:0] CH_LO_F = 8'h66;
  localparam logic [7:0] CH_LO_U = 8'h75;
  localparam logic [7:0] CH_LO_N = 8'h6E;
  localparam logic [7:0] CH_LO_C = 8'h63;

  // Keyword tracker codes: l, le, let; f, fu, fun, func.
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_L    = 3'd1;
  localparam logic [2:0] KW_LE   = 3'd2;
  localparam logic [2:0] KW_LET  = 3'd3;
  localparam logic [2:0] KW_F    = 3'd4;
  localparam logic [2:0] KW_FU   = 3'd5;
  localparam logic [2:0] KW_FUN  = 3'd6;
  localparam logic [2:0] KW_FUNC = 3'd7;

  localparam logic [CW-1:0] ONE = CW'(1);

  // Lexer state.
  mode_t         mode_r, mode_nxt;
  logic [1:0]    dot_r, dot_nxt;
  logic [2:0]    kw_r, kw_nxt;
  logic [CW-1:0] line_r, line_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] tstart_r, tstart_nxt;
  logic [CW-1:0] tline_r, tline_nxt;
  logic [CW-1:0] tlen_r, tlen_nxt;

  // Result queue.
  tok_t          ofifo_r [4];
  logic [1:0]    owr_r;
  logic [1:0]    ord_r;
  logic [2:0]    ocnt_r;

  logic          fire;
  logic          opop;
  logic          consumed;
  logic          run_reset;
  logic          case_v, idle_v, halt_v;
  tok_t          case_t, idle_t, halt_t;
  tok_t          res0, res1;
  logic [1:0]    nres;
  logic [1:0]    npush;
  logic [1:0]    halt_err;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == {CW{1'b1}}) ? v : v + ONE;
  endfunction

  function automatic logic [15:0] clamp16(input logic [CW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    clamp16 = (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [1:0] err,
                                  input logic [CW-1:0] line, input logic [CW-1:0] off,
                                  input logic [CW-1:0] len, input logic done);
    tok_t t;
    t.kind   = kind;
    t.err    = err;
    t.line   = clamp16(line);
    t.offset = clamp16(off);
    t.length = clamp16(len);
    t.done   = done;
    mk_tok   = t;
  endfunction

  function automatic logic [2:0] kw_next(input logic [2:0] s, input logic [7:0] c);
    logic [2:0] r;
    r = KW_NONE;
    if (s == KW_L && c == CH_LO_E) r = KW_LE;
    if (s == KW_LE && c == CH_LO_T) r = KW_LET;
    if (s == KW_F && c == CH_LO_U) r = KW_FU;
    if (s == KW_FU && c == CH_LO_N) r = KW_FUN;
    if (s == KW_FUN && c == CH_LO_C) r = KW_FUNC;
    kw_next = r;
  endfunction

  // An item enters only when the result queue can take two results.
  assign fire    = q_valid && (ocnt_r <= 3'd2);
  assign q_ready = fire;

  // Lexer step for one character.
  always_comb begin
    mode_nxt   = mode_r;
    dot_nxt    = dot_r;
    kw_nxt     = kw_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    tlen_nxt   = tlen_r;
    consumed   = 1'b0;
    run_reset  = 1'b0;
    case_v     = 1'b0;
    case_t     = '0;
    idle_v     = 1'b0;
    idle_t     = '0;
    halt_v     = 1'b0;
    halt_t     = '0;
    halt_err   = ERR_NONE;

    // Continue or finish the token in progress.
    unique case (mode_r)
      M_MINUS: begin
        if (q_cls.is_digit) begin
          mode_nxt = M_NUMBER;
          dot_nxt  = 2'd0;
          tlen_nxt = sat_inc(tlen_r);
          consumed = 1'b1;
        end else begin
          case_v   = 1'b1;
          case_t   = mk_tok(KIND_MINUS, ERR_NONE, tline_r, tstart_r, ONE, 1'b0);
          mode_nxt = M_IDLE;
        end
      end
      M_NUMBER: begin
        if (q_cls.is_digit || (q_cls.is_dot && dot_r < 2'd2)) begin
          if (q_cls.is_dot) begin
            dot_nxt = dot_r + 2'd1;
          end
          tlen_nxt = sat_inc(tlen_r);
          consumed = 1'b1;
        end else if (q_cls.is_alpha || dot_r >= 2'd2) begin
          case_v   = 1'b1;
          case_t   = mk_tok(KIND_INT, ERR_NUMBER, tline_r, tstart_r, tlen_r, 1'b0);
          mode_nxt = M_HALT1;
          consumed = 1'b1;
        end else begin
          case_v   = 1'b1;
          case_t   = mk_tok((dot_r != 2'd0) ? KIND_FLOAT : KIND_INT, ERR_NONE,
                            tline_r, tstart_r, tlen_r, 1'b0);
          mode_nxt = M_IDLE;
        end
      end
      M_IDENT: begin
        if (q_cls.is_alpha || q_cls.is_digit || q_cls.is_under) begin
          kw_nxt   = kw_next(kw_r, q_cls.code);
          tlen_nxt = sat_inc(tlen_r);
          consumed = 1'b1;
        end else begin
          case_v   = 1'b1;
          case_t   = mk_tok((kw_r == KW_LET) ? KIND_LET :
                            (kw_r == KW_FUNC) ? KIND_FUNC : KIND_IDENT,
                            ERR_NONE, tline_r, tstart_r, tlen_r, 1'b0);
          mode_nxt = M_IDLE;
        end
      end
      M_STRING: begin
        consumed = 1'b1;
        if (q_cls.is_quote) begin
          case_v   = 1'b1;
          case_t   = mk_tok(KIND_STRING, ERR_NONE, tline_r, tstart_r, tlen_r, 1'b0);
          mode_nxt = M_IDLE;
        end else if (q_cls.is_zero) begin
          case_v   = 1'b1;
          case_t   = mk_tok(KIND_INT, ERR_STRING, tline_r, tstart_r, tlen_r, 1'b0);
          mode_nxt = M_HALT2;
        end else begin
          tlen_nxt = sat_inc(tlen_r);
        end
      end
      M_IDLE: begin
        consumed = 1'b0;
      end
      default: begin
        consumed = 1'b1;
      end
    endcase

    // Start a new token, emit a single-character or end-of-run result, or skip a blank.
    if (!consumed && mode_nxt == M_IDLE) begin
      priority if (q_cls.is_zero) begin
        idle_v    = 1'b1;
        idle_t    = mk_tok(KIND_INT, ERR_NONE, line_r, pos_r, '0, 1'b1);
        run_reset = 1'b1;
      end else if (q_cls.is_nl) begin
        line_nxt = sat_inc(line_r);
      end else if (q_cls.is_ws) begin
        line_nxt = line_r;
      end else if (q_cls.is_digit || q_cls.is_minus || q_cls.is_alpha ||
                   q_cls.is_quote) begin
        tline_nxt  = line_r;
        dot_nxt    = 2'd0;
        kw_nxt     = KW_NONE;
        tstart_nxt = pos_r;
        tlen_nxt   = ONE;
        if (q_cls.is_digit) begin
          mode_nxt = M_NUMBER;
        end else if (q_cls.is_minus) begin
          mode_nxt = M_MINUS;
        end else if (q_cls.is_alpha) begin
          mode_nxt = M_IDENT;
          kw_nxt   = (q_cls.code == CH_LO_L) ? KW_L :
                     (q_cls.code == CH_LO_F) ? KW_F : KW_NONE;
        end else begin
          mode_nxt   = M_STRING;
          tstart_nxt = sat_inc(pos_r);
          tlen_nxt   = '0;
        end
      end else if (q_cls.is_op) begin
        idle_v = 1'b1;
        idle_t = mk_tok(q_cls.op_kind, ERR_NONE, line_r, pos_r, ONE, 1'b0);
      end else begin
        idle_v   = 1'b1;
        idle_t   = mk_tok(KIND_INT, ERR_ILLEGAL, line_r, pos_r, ONE, 1'b0);
        mode_nxt = M_HALT3;
      end
    end

    // End of input while halted closes the run with its error.
    if (mode_nxt == M_HALT1) halt_err = ERR_NUMBER;
    if (mode_nxt == M_HALT2) halt_err = ERR_STRING;
    if (mode_nxt == M_HALT3) halt_err = ERR_ILLEGAL;
    if (halt_err != ERR_NONE && q_cls.is_zero) begin
      halt_v    = 1'b1;
      halt_t    = mk_tok(KIND_INT, halt_err, line_r, pos_r, '0, 1'b1);
      run_reset = 1'b1;
    end else if (!q_cls.is_zero) begin
      pos_nxt = sat_inc(pos_r);
    end

    if (run_reset) begin
      mode_nxt   = M_IDLE;
      dot_nxt    = 2'd0;
      kw_nxt     = KW_NONE;
      line_nxt   = ONE;
      pos_nxt    = '0;
      tstart_nxt = '0;
      tline_nxt  = ONE;
      tlen_nxt   = '0;
    end
  end

  // Order the results of this character: token end, then new one, then close.
  always_comb begin
    res0  = case_v ? case_t : (idle_v ? idle_t : halt_t);
    res1  = (case_v && idle_v) ? idle_t : halt_t;
    nres  = 2'(case_v) + 2'(idle_v) + 2'(halt_v);
    npush = fire ? nres : 2'd0;
  end

  assign opop      = (ocnt_r != 3'd0) && out_ready;
  assign out_valid = (ocnt_r != 3'd0);

  // Result storage needs no reset.
  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      ofifo_r[owr_r] <= res0;
    end
    if (npush == 2'd2) begin
      ofifo_r[owr_r + 2'd1] <= res1;
    end
  end

  // Lexer state and result queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      dot_r    <= 2'd0;
      kw_r     <= KW_NONE;
      line_r   <= ONE;
      pos_r    <= '0;
      tstart_r <= '0;
      tline_r  <= ONE;
      tlen_r   <= '0;
      owr_r    <= '0;
      ord_r    <= '0;
      ocnt_r   <= '0;
    end else begin
      if (fire) begin
        mode_r   <= mode_nxt;
        dot_r    <= dot_nxt;
        kw_r     <= kw_nxt;
        line_r   <= line_nxt;
        pos_r    <= pos_nxt;
        tstart_r <= tstart_nxt;
        tline_r  <= tline_nxt;
        tlen_r   <= tlen_nxt;
      end
      owr_r  <= owr_r + npush;
      if (opop) begin
        ord_r <= ord_r + 2'd1;
      end
      ocnt_r <= ocnt_r + 3'(npush) - 3'(opop);
    end
  end

  assign out_token_kind   = ofifo_r[ord_r].kind;
  assign out_error_code   = ofifo_r[ord_r].err;
  assign out_start_line   = ofifo_r[ord_r].line;
  assign out_start_offset = ofifo_r[ord_r].offset;
  assign out_text_length  = ofifo_r[ord_r].length;
  assign out_stream_done  = ofifo_r[ord_r].done;

endmodule

FILE: tb/token_stream_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the tokenizer. Every accepted character is run
// through a software lexer that mirrors the block. The tokens it predicts
// wait in order until the block delivers its own result transactions.
module token_stream_checker
  import sct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  out_token_kind,
  input  logic [1:0]  out_error_code,
  input  logic [15:0] out_start_line,
  input  logic [15:0] out_start_offset,
  input  logic [15:0] out_text_length,
  input  logic        out_stream_done,
  output int unsigned fail_count,
  output int unsigned tokens_outstanding
);

  typedef enum logic [2:0] {
    LX_IDLE, LX_MINUS, LX_NUMBER, LX_IDENT, LX_STRING,
    LX_HALT_NUM, LX_HALT_STR, LX_HALT_ILL
  } lex_mode_e;

  // Progress through the two keywords, one state per matched letter.
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_L    = 3'd1;
  localparam logic [2:0] KW_LE   = 3'd2;
  localparam logic [2:0] KW_LET  = 3'd3;
  localparam logic [2:0] KW_F    = 3'd4;
  localparam logic [2:0] KW_FU   = 3'd5;
  localparam logic [2:0] KW_FUN  = 3'd6;
  localparam logic [2:0] KW_FUNC = 3'd7;

  lex_mode_e   mode;
  logic [1:0]  dots;
  logic [2:0]  kw;
  logic [15:0] line_no;
  logic [15:0] char_pos;
  logic [15:0] tok_off;
  logic [15:0] tok_line;
  logic [15:0] tok_len;

  tok_t        expected_tokens[$];
  int unsigned mismatches;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit lookup_operator(input logic [7:0] c, output logic [4:0] kind);
    lookup_operator = 1'b1;
    kind = KIND_INT;
    case (c)
      "(": kind = KIND_LPAREN;
      ")": kind = KIND_RPAREN;
      "=": kind = KIND_ASSIGN;
      "+": kind = KIND_PLUS;
      "-": kind = KIND_MINUS;
      "/": kind = KIND_SLASH;
      "*": kind = KIND_STAR;
      "%": kind = KIND_PERCENT;
      ";": kind = KIND_SEMI;
      ",": kind = KIND_COMMA;
      ".": kind = KIND_DOT;
      "{": kind = KIND_LBRACE;
      "}": kind = KIND_RBRACE;
      default: lookup_operator = 1'b0;
    endcase
  endfunction

  function automatic logic [2:0] kw_step(input logic [2:0] s, input logic [7:0] c);
    if (s == KW_L && c == "e") return KW_LE;
    if (s == KW_LE && c == "t") return KW_LET;
    if (s == KW_F && c == "u") return KW_FU;
    if (s == KW_FU && c == "n") return KW_FUN;
    if (s == KW_FUN && c == "c") return KW_FUNC;
    return KW_NONE;
  endfunction

  task automatic add_token(input logic [4:0] kind, input logic [1:0] err,
                           input logic [15:0] line, input logic [15:0] off,
                           input logic [15:0] len, input logic done);
    expected_tokens.push_back({kind, err, line, off, len, done});
  endtask

  task automatic lex_reset();
    mode = LX_IDLE;
    dots = 2'd0;
    kw = KW_NONE;
    line_no = 16'd1;
    char_pos = 16'd0;
    tok_off = 16'd0;
    tok_line = 16'd1;
    tok_len = 16'd0;
  endtask

  task automatic begin_token(input lex_mode_e m, input logic [15:0] off,
                             input logic [15:0] len);
    mode = m;
    tok_off = off;
    tok_line = line_no;
    tok_len = len;
    dots = 2'd0;
    kw = KW_NONE;
  endtask

  // A character seen between tokens either starts one, is an operator, is
  // skipped, ends the run, or is illegal and halts the run.
  task automatic lex_idle(input logic [7:0] c, input logic [15:0] pos);
    logic [4:0] op;
    if (c == CH_NUL) begin
      add_token(KIND_INT, ERR_NONE, line_no, pos, 16'd0, 1'b1);
      lex_reset();
    end else if (c == CH_NL) begin
      line_no = bump(line_no);
    end else if (c == CH_SPACE || c == CH_TAB) begin
    end else if (is_digit(c)) begin
      begin_token(LX_NUMBER, pos, 16'd1);
    end else if (c == CH_MINUS) begin
      begin_token(LX_MINUS, pos, 16'd1);
    end else if (is_alpha(c)) begin
      begin_token(LX_IDENT, pos, 16'd1);
      kw = (c == "l") ? KW_L : (c == "f") ? KW_F : KW_NONE;
    end else if (c == CH_QUOTE) begin
      begin_token(LX_STRING, bump(pos), 16'd0);
    end else if (lookup_operator(c, op)) begin
      add_token(op, ERR_NONE, line_no, pos, 16'd1, 1'b0);
    end else begin
      add_token(KIND_INT, ERR_ILLEGAL, line_no, pos, 16'd1, 1'b0);
      mode = LX_HALT_ILL;
    end
  endtask

  // One accepted character: finish or extend the token in progress, then
  // treat the character afresh if the token did not take it.
  task automatic lex_char(input logic [7:0] c);
    logic [15:0] pos;
    logic [4:0]  kind;
    logic [1:0]  err;
    bit          used;
    pos = char_pos;
    used = 1'b0;
    case (mode)
      LX_MINUS: begin
        if (is_digit(c)) begin
          mode = LX_NUMBER;
          dots = 2'd0;
          tok_len = bump(tok_len);
          used = 1'b1;
        end else begin
          add_token(KIND_MINUS, ERR_NONE, tok_line, tok_off, 16'd1, 1'b0);
          mode = LX_IDLE;
        end
      end
      LX_NUMBER: begin
        if (is_digit(c) || (c == CH_DOT && dots < 2'd2)) begin
          if (c == CH_DOT) dots = dots + 2'd1;
          tok_len = bump(tok_len);
          used = 1'b1;
        end else if (is_alpha(c) || dots >= 2'd2) begin
          add_token(KIND_INT, ERR_NUMBER, tok_line, tok_off, tok_len, 1'b0);
          mode = LX_HALT_NUM;
          used = 1'b1;
        end else begin
          kind = (dots != 2'd0) ? KIND_FLOAT : KIND_INT;
          add_token(kind, ERR_NONE, tok_line, tok_off, tok_len, 1'b0);
          mode = LX_IDLE;
        end
      end
      LX_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
          kw = kw_step(kw, c);
          tok_len = bump(tok_len);
          used = 1'b1;
        end else begin
          kind = (kw == KW_LET) ? KIND_LET : (kw == KW_FUNC) ? KIND_FUNC : KIND_IDENT;
          add_token(kind, ERR_NONE, tok_line, tok_off, tok_len, 1'b0);
          mode = LX_IDLE;
        end
      end
      LX_STRING: begin
        used = 1'b1;
        if (c == CH_QUOTE) begin
          add_token(KIND_STRING, ERR_NONE, tok_line, tok_off, tok_len, 1'b0);
          mode = LX_IDLE;
        end else if (c == CH_NUL) begin
          add_token(KIND_INT, ERR_STRING, tok_line, tok_off, tok_len, 1'b0);
          mode = LX_HALT_STR;
        end else begin
          tok_len = bump(tok_len);
        end
      end
      LX_IDLE: begin
      end
      default: used = 1'b1;
    endcase

    if (!used && mode == LX_IDLE) lex_idle(c, pos);

    // A halted run closes at the terminating byte with its error code.
    if (mode >= LX_HALT_NUM && c == CH_NUL) begin
      case (mode)
        LX_HALT_NUM: err = ERR_NUMBER;
        LX_HALT_STR: err = ERR_STRING;
        default:     err = ERR_ILLEGAL;
      endcase
      add_token(KIND_INT, err, line_no, pos, 16'd0, 1'b1);
      lex_reset();
    end else if (c != CH_NUL) begin
      char_pos = bump(char_pos);
    end
  endtask

  // Prediction on input transactions, comparison on result transactions.
  always @(posedge clk) begin : watch
    tok_t got;
    tok_t want;
    if (!rst_n) begin
      lex_reset();
      expected_tokens.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) lex_char(in_char_code);
      if (out_valid && out_ready) begin
        got = {out_token_kind, out_error_code, out_start_line, out_start_offset,
               out_text_length, out_stream_done};
        if (expected_tokens.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected token kind %0d err %0d line %0d off %0d len %0d done %0d",
                     $realtime, got.kind, got.err, got.line, got.offset, got.length, got.done);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind || got.err !== want.err || got.line !== want.line ||
              got.offset !== want.offset || got.length !== want.length ||
              got.done !== want.done) begin
            if (mismatches < 10) begin
              $display("%0t: token mismatch", $realtime);
              $display("  expected kind %0d err %0d line %0d off %0d len %0d done %0d",
                       want.kind, want.err, want.line, want.offset, want.length, want.done);
              $display("  actual   kind %0d err %0d line %0d off %0d len %0d done %0d",
                       got.kind, got.err, got.line, got.offset, got.length, got.done);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    tokens_outstanding <= expected_tokens.size();
  end

endmodule

FILE: tb/tb_script_char_tokenizer.sv
`timescale 1ns / 1ps

module tb_script_char_tokenizer;
  import sct_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_CHARS = 1800;
  localparam int unsigned SAT_RUN      = 40;
  localparam int unsigned TAIL_CYCLES  = 20;

  localparam string ALPHA = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string WORD  = {ALPHA, "0123456789_"};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_char_code = CH_NUL;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [4:0]  out_token_kind;
  logic [1:0]  out_error_code;
  logic [15:0] out_start_line;
  logic [15:0] out_start_offset;
  logic [15:0] out_text_length;
  logic        out_stream_done;

  int unsigned fail_count;
  int unsigned tokens_outstanding;
  int unsigned cycle_count;

  always #1 clk = ~clk;

  script_char_tokenizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_error_code   (out_error_code),
    .out_start_line   (out_start_line),
    .out_start_offset (out_start_offset),
    .out_text_length  (out_text_length),
    .out_stream_done  (out_stream_done)
  );

  token_stream_checker u_token_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token_kind     (out_token_kind),
    .out_error_code     (out_error_code),
    .out_start_line     (out_start_line),
    .out_start_offset   (out_start_offset),
    .out_text_length    (out_text_length),
    .out_stream_done    (out_stream_done),
    .fail_count         (fail_count),
    .tokens_outstanding (tokens_outstanding)
  );

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic append_str(ref logic [7:0] src[$], input string s);
    for (int i = 0; i < s.len(); i++) src.push_back(s[i]);
  endtask

  task automatic append_digits(ref logic [7:0] src[$], input int n);
    repeat (n) src.push_back(pick_char("0123456789"));
  endtask

  // Sends a source text one transaction per character. Valid stays high
  // after the last character so that a following text continues seamlessly.
  task automatic send_text(input logic [7:0] src[$], input bit gaps);
    int gap;
    foreach (src[i]) begin
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_char_code <= src[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
  endtask

  // Holds the sender off until every predicted token has been delivered.
  task automatic wait_for_all_tokens();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_outstanding != 0) @(posedge clk);
  endtask

  // Result side: random stalls, with calm stretches of no stalling at all.
  initial begin : result_sink
    bit calm;
    int stall;
    calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) calm = !calm;
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      stall = calm ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("script_char_tokenizer test failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  src[$];
    logic [7:0]  b;
    string       directed_src[8];
    int unsigned random_sent;
    int unsigned r;

    directed_src = '{
      "let lets fun func(-1 - x)=2.5;{a_1,\"s\n\"}%*/+.\t\n-",
      "7.1.2",
      "12a 5",
      "3..+",
      "\"ab",
      "ab@c",
      "-9.-",
      ""
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed runs: every token kind and operator, keyword near misses, a
    // held minus at end of input, a newline inside a string, and each error.
    foreach (directed_src[i]) begin
      src.delete();
      append_str(src, directed_src[i]);
      src.push_back(CH_NUL);
      send_text(src, 1'b1);
    end
    // Bytes above 127 are illegal, and later bytes are dropped until the end.
    src = '{8'hC3, 8'h80, "q", CH_NUL};
    send_text(src, 1'b1);
    wait_for_all_tokens();

    // Long stretches: many newlines, a long identifier, then a string that
    // spans a newline and a minus held at the end of input.
    src.delete();
    repeat (SAT_RUN) src.push_back(CH_NL);
    repeat (SAT_RUN) src.push_back("a");
    append_str(src, " \"q\n\" 1 -");
    src.push_back(CH_NUL);
    send_text(src, 1'b0);
    wait_for_all_tokens();

    // Random runs built mostly from well-formed tokens with some noise.
    random_sent = 0;
    while (random_sent < RANDOM_CHARS) begin
      src.delete();
      repeat ($urandom_range(1, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          if ($urandom_range(0, 3) == 0) src.push_back(CH_MINUS);
          append_digits(src, $urandom_range(1, 4));
        end else if (r < 25) begin
          append_digits(src, $urandom_range(1, 3));
          src.push_back(CH_DOT);
          append_digits(src, $urandom_range(0, 3));
          if ($urandom_range(0, 4) == 0) begin
            src.push_back(CH_DOT);
            append_digits(src, $urandom_range(0, 2));
          end
        end else if (r < 45) begin
          case ($urandom_range(0, 7))
            0: append_str(src, "let");
            1: append_str(src, "func");
            2: append_str(src, "lets");
            3: append_str(src, "fun");
            4: append_str(src, "fu_nc");
            default: begin
              src.push_back(pick_char(ALPHA));
              repeat ($urandom_range(0, 5)) src.push_back(pick_char(WORD));
            end
          endcase
        end else if (r < 60) begin
          src.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(1, 255));
            src.push_back((b == CH_QUOTE) ? CH_NL : b);
          end
          if ($urandom_range(0, 9) != 0) src.push_back(CH_QUOTE);
        end else if (r < 85) begin
          src.push_back(pick_char("()=+-/*%;,.{}"));
        end else if (r < 93) begin
          src.push_back(pick_char(" \t\n"));
        end else begin
          src.push_back(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 2) != 0) src.push_back(pick_char(" \t\n"));
      end
      src.push_back(CH_NUL);
      random_sent += src.size();
      send_text(src, $urandom_range(0, 4) != 0);
      if ($urandom_range(0, 5) == 0) wait_for_all_tokens();
    end

    wait_for_all_tokens();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("script_char_tokenizer test passed");
    end else begin
      $display("script_char_tokenizer test failed");
    end
    $finish;
  end

endmodule
